@@ sv/lsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants for the launch sequencer
// Phase and settle codes, register map, reset values, state and result types.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int PosW   = 21;  // signed position
  localparam int MagW   = 20;  // unsigned magnitudes
  localparam int CntW   = 5;
  localparam int TimeW  = 32;
  localparam int DelayW = 16;
  localparam int AddrW  = 5;
  localparam int RegIdxW = 3;
  localparam int InDataW  = 80;
  localparam int OutDataW = 48;

  // sequence phases
  localparam logic [1:0] PH_HOME = 2'd0;
  localparam logic [1:0] PH_MOVE = 2'd1;
  localparam logic [1:0] PH_FIRE = 2'd2;
  localparam logic [1:0] PH_HOLD = 2'd3;

  // settle qualifier phases (code 3 behaves as wait)
  localparam logic [1:0] ST_WAIT   = 2'd0;
  localparam logic [1:0] ST_SAMPLE = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_HOME_POS   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HOME_TOL   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SETTLE_BND = 3'd2;
  localparam logic [RegIdxW-1:0] REG_MIN_TGT    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_MAX_TGT    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_SETTLE_N   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_REL_DELAY  = 3'd6;

  // register reset values
  localparam logic signed [PosW-1:0] RST_HOME_POS   = -21'sd8000;
  localparam logic [MagW-1:0]        RST_HOME_TOL   = 20'd2000;
  localparam logic [MagW-1:0]        RST_SETTLE_BND = 20'd5000;
  localparam logic [MagW-1:0]        RST_MIN_TGT    = 20'd1000;
  localparam logic [MagW-1:0]        RST_MAX_TGT    = 20'd325010;
  localparam logic [CntW-1:0]        RST_SETTLE_N   = 5'd15;
  localparam logic [DelayW-1:0]      RST_REL_DELAY  = 16'd100;

  typedef struct packed {
    logic signed [PosW-1:0] home_position;
    logic [MagW-1:0]        home_tolerance;
    logic [MagW-1:0]        settle_band;
    logic [MagW-1:0]        min_target;
    logic [MagW-1:0]        max_target;
    logic [CntW-1:0]        settle_samples;
    logic [DelayW-1:0]      release_delay_ms;
  } lsc_cfg_t;

  typedef struct packed {
    logic [1:0]             seq_phase;
    logic [1:0]             settle_phase;
    logic [CntW-1:0]        sample_count;
    logic [CntW-1:0]        accept_count;
    logic signed [PosW-1:0] target;
    logic                   released;
    logic [TimeW-1:0]       fire_time;
    logic signed [PosW-1:0] fire_position;
  } lsc_state_t;

  typedef struct packed {
    logic [TimeW-1:0]       now_ms;
    logic [MagW-1:0]        command_target_um;
    logic signed [PosW-1:0] distance_um;
  } lsc_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] fire_position_um;
    logic                   range_error;
    logic                   fired;
    logic [1:0]             phase;
    logic                   latch_released;
    logic signed [PosW-1:0] target_um;
  } lsc_res_t;

  // magnitude of a 22-bit signed difference; -2^21 maps to 2^21 unsigned
  function automatic logic [PosW:0] abs22(input logic signed [PosW:0] v);
    abs22 = v[PosW] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ sv/launch_sequencer_with_settle_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// launch_sequencer_with_settle_check_core: launch sequencer top level
// Path: input register, then the tick logic into the result register.
// Throughput: one beat per cycle while out_tready keeps the result register
//   draining; the sequencer state updates once per beat.
// Reset: synchronous active-low rst_n; registers go to their defaults, the
//   sequence to home, all state cleared, both stages empty.
// ----------------------------------------------------------------------------
module launch_sequencer_with_settle_check_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: distance_um[20:0], command_target_um[40:21], now_ms[72:41], zero pad
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lsc_pkg::InDataW-1:0]   in_tdata,
  // out_tdata: target_um[20:0], latch_released[21], phase[23:22], fired[24],
  //            range_error[25], fire_position_um[46:26], zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lsc_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lsc_pkg::AddrW-1:0]     cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import lsc_pkg::*;

  lsc_cfg_t   cfg;
  lsc_state_t st_r, st_nxt;
  lsc_in_t    in_r;
  lsc_res_t   res;
  logic       in_vld_r, in_vld_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic       in_acc;
  logic       adv;

  lsc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  lsc_step u_step (
    .st    (st_r),
    .cfg   (cfg),
    .din   (in_r),
    .st_nxt(st_nxt),
    .res   (res)
  );

  // tick advances when the input register holds a beat and the result register is empty or being drained
  assign adv       = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  assign in_vld_nxt  = in_acc | (in_vld_r & ~adv);
  assign out_vld_nxt = adv | (out_vld_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_r <= in_tdata[$bits(lsc_in_t)-1:0];
    if (adv)    out_data_r <= {{(OutDataW - $bits(lsc_res_t)){1'b0}}, res};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/lsc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_cfg: APB register file
// Seven configuration registers at byte addresses 4*i, read back on prdata.
// ----------------------------------------------------------------------------
module lsc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lsc_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output lsc_pkg::lsc_cfg_t           cfg
);
  import lsc_pkg::*;

  lsc_cfg_t                cfg_r;
  logic                    wr_en;
  logic [RegIdxW-1:0]      idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[AddrW-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.home_position    <= RST_HOME_POS;
      cfg_r.home_tolerance   <= RST_HOME_TOL;
      cfg_r.settle_band      <= RST_SETTLE_BND;
      cfg_r.min_target       <= RST_MIN_TGT;
      cfg_r.max_target       <= RST_MAX_TGT;
      cfg_r.settle_samples   <= RST_SETTLE_N;
      cfg_r.release_delay_ms <= RST_REL_DELAY;
    end else if (wr_en) begin
      case (idx)
        REG_HOME_POS:   cfg_r.home_position    <= $signed(cfg_pwdata[PosW-1:0]);
        REG_HOME_TOL:   cfg_r.home_tolerance   <= cfg_pwdata[MagW-1:0];
        REG_SETTLE_BND: cfg_r.settle_band      <= cfg_pwdata[MagW-1:0];
        REG_MIN_TGT:    cfg_r.min_target       <= cfg_pwdata[MagW-1:0];
        REG_MAX_TGT:    cfg_r.max_target       <= cfg_pwdata[MagW-1:0];
        REG_SETTLE_N:   cfg_r.settle_samples   <= cfg_pwdata[CntW-1:0];
        REG_REL_DELAY:  cfg_r.release_delay_ms <= cfg_pwdata[DelayW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HOME_POS:   cfg_prdata = {{(32-PosW){cfg_r.home_position[PosW-1]}},
                                    cfg_r.home_position};
      REG_HOME_TOL:   cfg_prdata = {{(32-MagW){1'b0}}, cfg_r.home_tolerance};
      REG_SETTLE_BND: cfg_prdata = {{(32-MagW){1'b0}}, cfg_r.settle_band};
      REG_MIN_TGT:    cfg_prdata = {{(32-MagW){1'b0}}, cfg_r.min_target};
      REG_MAX_TGT:    cfg_prdata = {{(32-MagW){1'b0}}, cfg_r.max_target};
      REG_SETTLE_N:   cfg_prdata = {{(32-CntW){1'b0}}, cfg_r.settle_samples};
      REG_REL_DELAY:  cfg_prdata = {{(32-DelayW){1'b0}}, cfg_r.release_delay_ms};
      default:        cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/lsc_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_step: one control tick of the launch sequencer
// Next-state and result logic for the home / move / fire / hold sequence.
// ----------------------------------------------------------------------------
module lsc_step (
  input  lsc_pkg::lsc_state_t st,
  input  lsc_pkg::lsc_cfg_t   cfg,
  input  lsc_pkg::lsc_in_t    din,
  output lsc_pkg::lsc_state_t st_nxt,
  output lsc_pkg::lsc_res_t   res
);
  import lsc_pkg::*;

  logic signed [PosW:0]   home_diff;
  logic                   at_home;
  logic signed [PosW:0]   tgt_ext;
  logic                   out_of_range;
  logic signed [PosW:0]   err;
  logic                   in_band;
  logic [CntW-1:0]        sample_inc;
  logic [CntW+2:0]        acc_x5;
  logic [CntW+2:0]        smp_x4;
  logic                   settle_pass;
  logic [TimeW-1:0]       elapsed;
  logic                   fired;
  logic                   range_error;

  assign home_diff = {din.distance_um[PosW-1], din.distance_um}
                   - {cfg.home_position[PosW-1], cfg.home_position};
  assign at_home   = (abs22(home_diff) < {2'b00, cfg.home_tolerance})
                   && (din.distance_um != '0);

  assign tgt_ext      = {st.target[PosW-1], st.target};
  assign out_of_range = (tgt_ext > $signed({2'b00, cfg.max_target}))
                     || (tgt_ext < $signed({2'b00, cfg.min_target}));

  assign err     = tgt_ext - {din.distance_um[PosW-1], din.distance_um};
  assign in_band = abs22(err) < {2'b00, cfg.settle_band};

  assign sample_inc  = st.sample_count + 1'b1;
  assign acc_x5      = {st.accept_count, 2'b00} + {3'b000, st.accept_count};
  assign smp_x4      = {1'b0, st.sample_count, 2'b00};
  assign settle_pass = acc_x5 > smp_x4;

  assign elapsed = din.now_ms - st.fire_time;

  always_comb begin
    st_nxt      = st;
    fired       = 1'b0;
    range_error = 1'b0;
    case (st.seq_phase)
      PH_HOME: begin
        st_nxt.target = cfg.home_position;
        if (at_home) begin
          st_nxt.released = 1'b0;
          st_nxt.target   = din.distance_um;
          if (din.command_target_um != '0) begin
            st_nxt.seq_phase = PH_MOVE;
            st_nxt.target    = $signed({1'b0, din.command_target_um});
          end
        end
      end
      PH_MOVE: begin
        if (out_of_range) begin
          st_nxt.target = '0;
          range_error   = 1'b1;
        end else begin
          case (st.settle_phase)
            ST_SAMPLE: begin
              st_nxt.sample_count = sample_inc;
              if (in_band) st_nxt.accept_count = st.accept_count + 1'b1;
              if (sample_inc >= cfg.settle_samples) st_nxt.settle_phase = ST_CHECK;
            end
            ST_CHECK: begin
              st_nxt.settle_phase = ST_WAIT;
              if (settle_pass) st_nxt.seq_phase = PH_FIRE;
            end
            default: begin
              if (in_band) begin
                st_nxt.settle_phase = ST_SAMPLE;
                st_nxt.sample_count = '0;
                st_nxt.accept_count = '0;
              end
            end
          endcase
        end
      end
      PH_FIRE: begin
        st_nxt.released      = 1'b1;
        st_nxt.seq_phase     = PH_HOLD;
        st_nxt.fire_time     = din.now_ms;
        st_nxt.fire_position = din.distance_um;
        fired                = 1'b1;
      end
      default: begin
        if (elapsed > {{(TimeW-DelayW){1'b0}}, cfg.release_delay_ms})
          st_nxt.seq_phase = PH_HOME;
      end
    endcase
  end

  assign res.target_um        = st_nxt.target;
  assign res.latch_released   = st_nxt.released;
  assign res.phase            = st_nxt.seq_phase;
  assign res.fired            = fired;
  assign res.range_error      = range_error;
  assign res.fire_position_um = st_nxt.fire_position;

endmodule

@@ sv/lsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_checker: port-level checks for the launch sequencer
// Watches the result channel for handshake holds and phase/flag consistency.
// ----------------------------------------------------------------------------
module lsc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [lsc_pkg::OutDataW-1:0]  out_tdata
);
  import lsc_pkg::*;

  lsc_res_t r;
  assign r = out_tdata[$bits(lsc_res_t)-1:0];

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a shot lands in hold with the latch released
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.fired |-> r.phase == PH_HOLD && r.latch_released)
    else $error("fired beat without hold phase and released latch");

  // out-of-range clears the target and stays in move
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.range_error |-> r.phase == PH_MOVE && r.target_um == '0 && !r.fired)
    else $error("range error beat inconsistent");

  // the latch is engaged throughout move and fire
  a_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (r.phase == PH_MOVE || r.phase == PH_FIRE) |-> !r.latch_released)
    else $error("latch released before firing");

endmodule

bind launch_sequencer_with_settle_check_core lsc_checker u_lsc_checker (.*);
